// ===== design/repc_pkg.sv =====
// Shared types and constants for the radar echo polar-to-Cartesian unit.
// No dependencies; imported by every other design file except repc_req_if.sv and repc_checker.sv.
package repc_pkg;

   localparam int CORDIC_ITERS = 24;
   localparam int QUOT_BITS    = 20;
   localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;
   localparam logic [20:0] COORD_LIMIT = 21'd1048575;

   localparam logic [1:0] REG_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_NEAR      = 2'd1;
   localparam logic [1:0] REG_FAR       = 2'd2;
   localparam logic [1:0] REG_SPP       = 2'd3;

   localparam logic [31:0] ATAN_TURNS [CORDIC_ITERS] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
   };

   // Word riding along the pipeline: valid flag plus the fields still needed.
   typedef struct packed {
      logic       valid;
      logic [9:0] sample_index;
      logic [7:0] level;
   } side_type;

endpackage

// ===== design/repc_req_if.sv =====
// Request channel of the polar-to-Cartesian unit: valid/ready plus echo sample.
// No dependencies.
interface repc_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] spoke_angle;
   logic [9:0]  sample_index;
   logic [7:0]  echo_level;
   modport source (output valid, spoke_angle, sample_index, echo_level, input ready);
   modport sink (input valid, spoke_angle, sample_index, echo_level, output ready);
endinterface

// Response channel: valid/ready plus one Cartesian point.
interface repc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [20:0] x_pos;
   logic signed [20:0] y_pos;
   logic [7:0]         point_level;
   modport source (output valid, x_pos, y_pos, point_level, input ready);
   modport sink (input valid, x_pos, y_pos, point_level, output ready);
endinterface

// ===== design/repc_cordic.sv =====
// Pipelined rotation-mode CORDIC, one iteration per stage, Q1.15 sine/cosine out.
// Depends on repc_pkg.
module repc_cordic import repc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  side_type           side_in,
   input  logic [31:0]        phase_in,
   output side_type           side_out,
   output logic signed [16:0] cos_out,
   output logic signed [16:0] sin_out
);

   side_type           side_ff [CORDIC_ITERS+1];
   logic signed [32:0] x_ff [CORDIC_ITERS+1];
   logic signed [32:0] y_ff [CORDIC_ITERS+1];
   logic signed [32:0] z_ff [CORDIC_ITERS+1];
   logic               flip_ff [CORDIC_ITERS+1];
   logic signed [32:0] x_in [CORDIC_ITERS+1];
   logic signed [32:0] y_in [CORDIC_ITERS+1];
   logic signed [32:0] z_in [CORDIC_ITERS+1];
   logic               flip_in;
   logic [31:0]        phase_adj;
   side_type           side_last_ff;
   logic signed [16:0] cos_ff, sin_ff, cos_in, sin_in;

   // Fold the second and third quadrants onto the right half plane.
   always_comb begin
      flip_in   = (phase_in[31:30] == 2'd1) || (phase_in[31:30] == 2'd2);
      phase_adj = flip_in ? (phase_in - 32'h8000_0000) : phase_in;
      x_in[0]   = CORDIC_GAIN_Q30;
      y_in[0]   = '0;
      z_in[0]   = {{1{phase_adj[31]}}, phase_adj};
   end

   for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
      logic signed [32:0] dx, dy;
      always_comb begin
         dx = x_ff[i] >>> i;
         dy = y_ff[i] >>> i;
         if (!z_ff[i][32]) begin
            x_in[i+1] = x_ff[i] - dy;
            y_in[i+1] = y_ff[i] + dx;
            z_in[i+1] = z_ff[i] - signed'({1'b0, ATAN_TURNS[i]});
         end else begin
            x_in[i+1] = x_ff[i] + dy;
            y_in[i+1] = y_ff[i] - dx;
            z_in[i+1] = z_ff[i] + signed'({1'b0, ATAN_TURNS[i]});
         end
      end
   end

   function automatic logic signed [16:0] to_q15(input logic signed [32:0] v, input logic neg);
      logic signed [33:0] t;
      logic signed [18:0] r;
      begin
         t = neg ? -34'(v) : 34'(v);
         t = t + 34'sd16384;
         r = 19'(t >>> 15);
         if (r > 19'sd32768)
            r = 19'sd32768;
         if (r < -19'sd32768)
            r = -19'sd32768;
         return 17'(r);
      end
   endfunction

   always_comb begin
      cos_in = to_q15(x_ff[CORDIC_ITERS], flip_ff[CORDIC_ITERS]);
      sin_in = to_q15(y_ff[CORDIC_ITERS], flip_ff[CORDIC_ITERS]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= CORDIC_ITERS; k++) side_ff[k] <= '0;
         side_last_ff <= '0;
      end else if (en) begin
         side_ff[0] <= side_in;
         for (int k = 1; k <= CORDIC_ITERS; k++) side_ff[k] <= side_ff[k-1];
         side_last_ff <= side_ff[CORDIC_ITERS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         flip_ff[0] <= flip_in;
         for (int k = 0; k <= CORDIC_ITERS; k++) begin
            x_ff[k] <= x_in[k];
            y_ff[k] <= y_in[k];
            z_ff[k] <= z_in[k];
         end
         for (int k = 1; k <= CORDIC_ITERS; k++) flip_ff[k] <= flip_ff[k-1];
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign side_out = side_last_ff;
   assign cos_out  = cos_ff;
   assign sin_out  = sin_ff;

endmodule

// ===== design/repc_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, saturating signed result.
// Depends on repc_pkg.
module repc_divider import repc_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  logic [30:0]        rem_in,
   input  logic               sat_in,
   input  logic               neg_in,
   input  logic [10:0]        spp,
   output logic signed [20:0] coord_out
);

   logic [30:0]          rem_ff [QUOT_BITS];
   logic [QUOT_BITS-1:0] quot_ff [QUOT_BITS];
   logic                 sat_ff [QUOT_BITS];
   logic                 neg_ff [QUOT_BITS];
   logic [30:0]          rem_in_s [QUOT_BITS];
   logic [QUOT_BITS-1:0] quot_in [QUOT_BITS];
   logic [20:0]          mag;

   for (genvar k = 0; k < QUOT_BITS; k++) begin : g_step
      logic [30:0]          rem_src, trial;
      logic [QUOT_BITS-1:0] quot_src;
      always_comb begin
         rem_src  = (k == 0) ? rem_in : rem_ff[(k == 0) ? 0 : k-1];
         quot_src = (k == 0) ? '0 : quot_ff[(k == 0) ? 0 : k-1];
         trial    = 31'(spp) << (QUOT_BITS-1-k);
         quot_in[k] = quot_src;
         if (rem_src >= trial) begin
            rem_in_s[k] = rem_src - trial;
            quot_in[k][QUOT_BITS-1-k] = 1'b1;
         end else begin
            rem_in_s[k] = rem_src;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sat_ff[0] <= sat_in;
         neg_ff[0] <= neg_in;
         for (int k = 0; k < QUOT_BITS; k++) begin
            rem_ff[k]  <= rem_in_s[k];
            quot_ff[k] <= quot_in[k];
         end
         for (int k = 1; k < QUOT_BITS; k++) begin
            sat_ff[k] <= sat_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
         end
      end
   end

   always_comb begin
      mag       = sat_ff[QUOT_BITS-1] ? COORD_LIMIT : {1'b0, quot_ff[QUOT_BITS-1]};
      coord_out = neg_ff[QUOT_BITS-1] ? -signed'(mag) : signed'(mag);
   end

endmodule

// ===== design/repc_scale.sv =====
// Range formation, range times sine/cosine, and rounded division by the sample count.
// Depends on repc_pkg and repc_divider.
module repc_scale import repc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  side_type           side_in,
   input  logic signed [16:0] cos_in,
   input  logic signed [16:0] sin_in,
   input  logic [19:0]        near_range,
   input  logic [19:0]        far_range,
   input  logic [10:0]        spp,
   output side_type           side_out,
   output logic signed [20:0] x_out,
   output logic signed [20:0] y_out
);

   side_type           side_ff [3+QUOT_BITS];
   logic signed [32:0] rnum_ff, rnum_in;
   logic signed [16:0] cos_ff, sin_ff;
   logic signed [49:0] px_ff, py_ff;
   logic [30:0]        remx_ff, remy_ff, remx_in, remy_in;
   logic               satx_ff, saty_ff, negx_ff, negy_ff, satx_in, saty_in;
   logic signed [20:0] span;

   always_comb begin
      span    = signed'({1'b0, far_range}) - signed'({1'b0, near_range});
      rnum_in = signed'(33'(near_range * spp))
              + 33'(signed'({1'b0, side_in.sample_index}) * span);
   end

   function automatic logic [31:0] prep(input logic signed [49:0] p, input logic [10:0] d);
      logic [48:0] mag;
      logic [49:0] biased;
      logic [34:0] m;
      logic        sat;
      begin
         mag    = p[49] ? 49'(-p) : 49'(p);
         biased = 50'(mag) + (50'(d) << 14);
         m      = 35'(biased >> 15);
         sat    = m >= (35'(d) << QUOT_BITS);
         return {sat, m[30:0]};
      end
   endfunction

   assign {satx_in, remx_in} = prep(px_ff, spp);
   assign {saty_in, remy_in} = prep(py_ff, spp);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3+QUOT_BITS; k++) side_ff[k] <= '0;
      end else if (en) begin
         side_ff[0] <= side_in;
         for (int k = 1; k < 3+QUOT_BITS; k++) side_ff[k] <= side_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rnum_ff <= rnum_in;
         cos_ff  <= cos_in;
         sin_ff  <= sin_in;
         px_ff   <= 50'(rnum_ff * cos_ff);
         py_ff   <= 50'(rnum_ff * sin_ff);
         remx_ff <= remx_in;
         remy_ff <= remy_in;
         satx_ff <= satx_in;
         saty_ff <= saty_in;
         negx_ff <= px_ff[49];
         negy_ff <= py_ff[49];
      end
   end

   repc_divider u_div_x (
      .clock(clock), .en(en), .rem_in(remx_ff), .sat_in(satx_ff), .neg_in(negx_ff),
      .spp(spp), .coord_out(x_out)
   );

   repc_divider u_div_y (
      .clock(clock), .en(en), .rem_in(remy_ff), .sat_in(saty_ff), .neg_in(negy_ff),
      .spp(spp), .coord_out(y_out)
   );

   assign side_out = side_ff[2+QUOT_BITS];

endmodule

// ===== design/radar_echo_polar_to_cartesian_unit.sv =====
// Top level of the radar echo polar-to-Cartesian unit: config registers, pipeline, output.
// Depends on repc_pkg, repc_req_if/repc_rsp_if, repc_cordic and repc_scale.
//
// Converts one radar echo word per clock, unless the output is stalled, into a Cartesian
// point. A word whose echo_level is strictly above the intensity threshold yields one
// response word with x = range*cos(angle), y = range*sin(angle) in 1/16 m (rounded to
// nearest, saturated to +-1048575) and the echo level; other words yield nothing. Range
// is near + index*(far-near)/samples_per_spoke. The pipeline holds the entry register,
// 25 CORDIC iteration registers plus the rounding register, range, product and
// divider-prep registers, a 20-stage restoring divider (one quotient bit per stage) and
// the output register. The whole pipeline advances together whenever the output
// register is empty or being taken, so req ready equals "output free or rsp ready".
// Write the configuration registers only while the pipeline is drained.
module radar_echo_polar_to_cartesian_unit import repc_pkg::*; #(
   parameter int ANGLE_BITS  = 16,
   parameter int MAX_SAMPLES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   repc_req_if.sink    req_if,
   repc_rsp_if.source  rsp_if,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [19:0] csr_write_data
);

   localparam int KEEP_BITS = (ANGLE_BITS < 16) ? ANGLE_BITS : 16;
   localparam int SPP_CAP   = (MAX_SAMPLES > 2047) ? 2047 : MAX_SAMPLES;
   localparam logic [15:0] ANGLE_MASK = 16'((64'd1 << KEEP_BITS) - 64'd1);

   logic [7:0]  thresh_ff;
   logic [19:0] near_ff, far_ff;
   logic [10:0] spp_ff, spp_eff;
   logic        en;

   side_type           entry_side_ff, entry_side_in;
   logic [31:0]        entry_phase_ff, entry_phase_in;
   side_type           cordic_side, scale_side;
   logic signed [16:0] cos_q15, sin_q15;
   logic signed [20:0] x_calc, y_calc;

   logic               rsp_valid_ff;
   logic signed [20:0] x_ff, y_ff;
   logic [7:0]         level_ff;

   // Configuration writes; unknown indexes cannot occur with a 2-bit index.
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= '0;
         near_ff   <= '0;
         far_ff    <= '0;
         spp_ff    <= 11'd1024;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_THRESHOLD: thresh_ff <= csr_write_data[7:0];
            REG_NEAR:      near_ff   <= csr_write_data;
            REG_FAR:       far_ff    <= csr_write_data;
            REG_SPP:       spp_ff    <= csr_write_data[10:0];
            default:       ;
         endcase
      end
   end

   // Clamp the sample count: zero acts as one, large values cap at the supported maximum.
   always_comb begin
      if (spp_ff == '0)
         spp_eff = 11'd1;
      else if (32'(spp_ff) > SPP_CAP)
         spp_eff = 11'(SPP_CAP);
      else
         spp_eff = spp_ff;
   end

   // Advance everything when the output slot is free or being drained.
   assign en           = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = en;

   // Entry stage: drop words at or below threshold, map the angle to a 32-bit phase.
   always_comb begin
      entry_side_in.valid        = req_if.valid && (req_if.echo_level > thresh_ff);
      entry_side_in.sample_index = req_if.sample_index;
      entry_side_in.level        = req_if.echo_level;
      entry_phase_in = 32'(req_if.spoke_angle & ANGLE_MASK) << (32 - ANGLE_BITS);
   end

   always_ff @(posedge clock) begin
      if (reset)
         entry_side_ff <= '0;
      else if (en)
         entry_side_ff <= entry_side_in;
   end

   always_ff @(posedge clock) begin
      if (en)
         entry_phase_ff <= entry_phase_in;
   end

   repc_cordic u_cordic (
      .clock(clock), .reset(reset), .en(en),
      .side_in(entry_side_ff), .phase_in(entry_phase_ff),
      .side_out(cordic_side), .cos_out(cos_q15), .sin_out(sin_q15)
   );

   repc_scale u_scale (
      .clock(clock), .reset(reset), .en(en),
      .side_in(cordic_side), .cos_in(cos_q15), .sin_in(sin_q15),
      .near_range(near_ff), .far_range(far_ff), .spp(spp_eff),
      .side_out(scale_side), .x_out(x_calc), .y_out(y_calc)
   );

   // Output register: hold the word until the sink takes it.
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (en)
         rsp_valid_ff <= scale_side.valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff     <= x_calc;
         y_ff     <= y_calc;
         level_ff <= scale_side.level;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.x_pos       = x_ff;
   assign rsp_if.y_pos       = y_ff;
   assign rsp_if.point_level = level_ff;

endmodule

// ===== design/repc_checker.sv =====
// Port-level checks for the polar-to-Cartesian unit, bound onto the top level.
// Depends on repc_req_if/repc_rsp_if signals as seen at the top level ports.
module repc_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [20:0] x_pos,
   input logic signed [20:0] y_pos,
   input logic [7:0]         point_level
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(x_pos) && $stable(y_pos)
      && $stable(point_level))
      else $error("response word changed while stalled");

   a_ready_follows_out: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not track output slot");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_coord_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (x_pos != -21'sd1048576) && (y_pos != -21'sd1048576))
      else $error("coordinate outside saturation range");

endmodule

bind radar_echo_polar_to_cartesian_unit repc_checker u_repc_checker (
   .clock(clock), .reset(reset), .req_ready(req_if.ready), .rsp_valid(rsp_if.valid),
   .rsp_ready(rsp_if.ready), .x_pos(rsp_if.x_pos), .y_pos(rsp_if.y_pos),
   .point_level(rsp_if.point_level)
);

// ===== tb/tb.sv =====
// Testbench for radar_echo_polar_to_cartesian_unit: directed, configuration and random tests.
// Depends on repc_pkg, repc_req_if/repc_rsp_if and the unit's RTL; the checker predicts each
// point with its own CORDIC, range and rounding arithmetic.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import repc_pkg::*;

   localparam int PIPE_DEPTH = 51;   // pipeline depth of the top level
   localparam int MAX_SPP    = 1024;

   typedef struct {
      logic signed [20:0] x_pos;
      logic signed [20:0] y_pos;
      logic [7:0]         point_level;
   } point_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_en = 1'b0;
   logic [1:0]  csr_index = REG_THRESHOLD;
   logic [19:0] csr_write_data = '0;

   repc_req_if req_bus ();
   repc_rsp_if rsp_bus ();

   radar_echo_polar_to_cartesian_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_bus.sink),
      .rsp_if         (rsp_bus.source),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always #5 clock = ~clock;

   // Shadow copies of the configuration registers.
   bit [7:0]  cfg_threshold = 8'd0;
   bit [19:0] cfg_near      = 20'd0;
   bit [19:0] cfg_far       = 20'd0;
   bit [10:0] cfg_spp       = 11'd1024;

   point_type pending_points[$];
   int     error_count = 0;
   bit     sender_no_idle = 1'b0;   // stretch with no gaps on the request side
   bit     sink_no_idle   = 1'b0;

   // Pick a gap length: mostly none, sometimes short, a few long.
   function automatic int pick_gap(bit no_idle);
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Round a Q1.30 CORDIC output to Q1.15 (half up), clamped to +-1.0.
   function automatic longint round_q15(longint v);
      longint r;
      r = (v + 64'sd16384) >>> 15;
      if (r > 32768) r = 32768;
      if (r < -32768) r = -32768;
      return r;
   endfunction

   // Rotation-mode CORDIC with quadrant fold: cosine and sine of the bearing in Q1.15.
   task automatic bearing_sin_cos(input bit [15:0] angle, output longint cos_q, output longint sin_q);
      bit [31:0] phase;
      bit        flip;
      longint    x, y, z, dx, dy;
      phase = {angle, 16'h0000};
      flip  = (phase[31:30] == 2'd1) || (phase[31:30] == 2'd2);
      if (flip) phase = phase - 32'h8000_0000;
      x = longint'(CORDIC_GAIN_Q30);
      y = 0;
      z = longint'($signed(phase));
      for (int i = 0; i < CORDIC_ITERS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - longint'(ATAN_TURNS[i]);
         end else begin
            x = x + dx; y = y - dy; z = z + longint'(ATAN_TURNS[i]);
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      cos_q = round_q15(x);
      sin_q = round_q15(y);
   endtask

   // num/den rounded to nearest, ties away from zero, saturated to the coordinate limit.
   function automatic logic signed [20:0] scale_coord(longint num, longint den);
      longint mag, q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      if (q > longint'(COORD_LIMIT)) q = longint'(COORD_LIMIT);
      if (num < 0) q = -q;
      return q[20:0];
   endfunction

   // Work out the point an echo word produces, if any, and queue it.
   task automatic predict_point(input bit [15:0] angle, input bit [9:0] idx, input bit [7:0] lvl);
      longint spp, span, rnum, c, s, den;
      point_type p;
      if (lvl <= cfg_threshold) return;
      spp = cfg_spp;
      if (spp < 1) spp = 1;
      if (spp > MAX_SPP) spp = MAX_SPP;
      span = longint'(cfg_far) - longint'(cfg_near);
      rnum = longint'(cfg_near) * spp + longint'(idx) * span;
      bearing_sin_cos(angle, c, s);
      den = spp << 15;
      p.x_pos = scale_coord(rnum * c, den);
      p.y_pos = scale_coord(rnum * s, den);
      p.point_level = lvl;
      pending_points.push_back(p);
   endtask

   // Send one echo word; return after it is accepted, at the following falling edge.
   task automatic send_echo(input bit [15:0] angle, input bit [9:0] idx, input bit [7:0] lvl);
      int gap;
      gap = pick_gap(sender_no_idle);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.spoke_angle  = angle;
      req_bus.sample_index = idx;
      req_bus.echo_level   = lvl;
      req_bus.valid        = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      predict_point(angle, idx, lvl);
      @(negedge clock);
   endtask

   task automatic send_random_echo();
      bit [9:0] idx;
      // Indexes over the whole 10-bit range, some past the end of shorter spokes.
      idx = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 1023));
      send_echo(16'($urandom), idx, 8'($urandom));
   endtask

   // Wait until every expected point has come, then let in-flight words clear.
   task automatic drain_pipe();
      req_bus.valid = 1'b0;
      while (pending_points.size() != 0) @(negedge clock);
      repeat (PIPE_DEPTH + 6) @(negedge clock);
   endtask

   // Write one register; call only while drained, at a falling edge.
   task automatic write_reg(input logic [1:0] index, input bit [19:0] data);
      csr_write_en   = 1'b1;
      csr_index      = index;
      csr_write_data = data;
      case (index)
         REG_THRESHOLD: cfg_threshold = data[7:0];
         REG_NEAR:      cfg_near      = data;
         REG_FAR:       cfg_far       = data;
         REG_SPP:       cfg_spp       = data[10:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   task automatic set_config(input bit [7:0] thr, input bit [19:0] near_r, input bit [19:0] far_r,
                             input bit [10:0] spp);
      write_reg(REG_THRESHOLD, {12'd0, thr});
      write_reg(REG_NEAR, near_r);
      write_reg(REG_FAR, far_r);
      write_reg(REG_SPP, {9'd0, spp});
   endtask

   // Directed: cardinal and edge bearings, extreme indexes and levels, threshold edges.
   task automatic test_directed();
      set_config(8'd0, 20'd1000, 20'd100000, 11'd1024);
      send_echo(16'd0, 10'd0, 8'd1);
      send_echo(16'd16384, 10'd1023, 8'd255);
      send_echo(16'd32768, 10'd512, 8'd128);
      send_echo(16'd49152, 10'd1, 8'd2);
      send_echo(16'd65535, 10'd1023, 8'd255);
      send_echo(16'd8192, 10'd700, 8'd0);       // at threshold: dropped
      send_echo(16'd16383, 10'd300, 8'd77);
      send_echo(16'd32767, 10'd300, 8'd77);
      send_echo(16'd1, 10'd1023, 8'd200);
      drain_pipe();
      // Far range below near: range shrinks with the index.
      set_config(8'd100, 20'd1048575, 20'd0, 11'd256);
      send_echo(16'd24576, 10'd0, 8'd100);      // equal to threshold: dropped
      send_echo(16'd24576, 10'd0, 8'd101);
      send_echo(16'd40960, 10'd1023, 8'd255);   // index past spoke end
      drain_pipe();
      // Zero samples per spoke acts as one; huge extrapolation saturates.
      set_config(8'd0, 20'd1048575, 20'd1048575, 11'd0);
      send_echo(16'd0, 10'd1023, 8'd9);
      send_echo(16'd8192, 10'd1023, 8'd9);
      drain_pipe();
      set_config(8'd0, 20'd0, 20'd1048575, 11'd1);
      send_echo(16'd57344, 10'd1023, 8'd9);
      drain_pipe();
      // Oversized samples per spoke is clamped to the maximum.
      set_config(8'd0, 20'd5, 20'd1048575, 11'd2047);
      send_echo(16'd12345, 10'd1023, 8'd33);
      send_echo(16'd54321, 10'd0, 8'd33);
      drain_pipe();
      // Threshold at maximum: nothing passes.
      set_config(8'd255, 20'd500, 20'd600, 11'd1024);
      send_echo(16'd100, 10'd10, 8'd255);
      send_echo(16'd200, 10'd20, 8'd0);
      drain_pipe();
   endtask

   // Random words under a series of random and extreme configurations.
   task automatic test_random_phases();
      for (int ph = 0; ph < 10; ph++) begin
         case (ph)
            0: set_config(8'd0, 20'd0, 20'd1048575, 11'd1024);
            1: set_config(8'd255, 20'd1048575, 20'd0, 11'd1);
            2: set_config(8'd0, 20'd1048575, 20'd1048575, 11'd2047);
            default: set_config(8'($urandom_range(0, 200)), 20'($urandom), 20'($urandom),
                                11'($urandom_range(0, 2047)));
         endcase
         sender_no_idle = (ph % 3 == 2);
         sink_no_idle   = (ph % 4 == 1);
         for (int n = 0; n < 125; n++) begin
            send_random_echo();
            // Hold off the sender until every point is back, once per phase.
            if (n == 60) drain_pipe();
         end
         drain_pipe();
      end
      sender_no_idle = 1'b0;
      sink_no_idle   = 1'b0;
   endtask

   // Response side: drive ready with random stalls.
   initial begin
      int gap;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready = 1'b1;
         gap = pick_gap(sink_no_idle);
         if (gap > 0) begin
            @(negedge clock);
            rsp_bus.ready = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   end

   // Compare each accepted point with the oldest expectation.
   always @(posedge clock) begin
      point_type p;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_points.size() == 0) begin
            $error("unexpected point x=%0d y=%0d level=%0d", rsp_bus.x_pos, rsp_bus.y_pos,
                   rsp_bus.point_level);
            error_count++;
         end else begin
            p = pending_points.pop_front();
            if (rsp_bus.x_pos !== p.x_pos) begin
               $error("x_pos expected %0d got %0d", p.x_pos, rsp_bus.x_pos);
               error_count++;
            end
            if (rsp_bus.y_pos !== p.y_pos) begin
               $error("y_pos expected %0d got %0d", p.y_pos, rsp_bus.y_pos);
               error_count++;
            end
            if (rsp_bus.point_level !== p.point_level) begin
               $error("point_level expected %0d got %0d", p.point_level, rsp_bus.point_level);
               error_count++;
            end
         end
      end
   end

   initial begin
      #(5ms);
      $display("tb: errors");
      $finish;
   end

   initial begin
      req_bus.valid        = 1'b0;
      req_bus.spoke_angle  = '0;
      req_bus.sample_index = '0;
      req_bus.echo_level   = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random_phases();
      drain_pipe();
      if (pending_points.size() != 0) begin
         $error("%0d expected points never arrived", pending_points.size());
         error_count++;
      end
      if (error_count == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end
endmodule

// ===== filelist.f =====
design/repc_pkg.sv
design/repc_req_if.sv
design/repc_cordic.sv
design/repc_divider.sv
design/repc_scale.sv
design/radar_echo_polar_to_cartesian_unit.sv
design/repc_checker.sv
tb/tb.sv
